// File: design/drx_pkg.sv
// shared types, constants and checksum function for the dle frame receiver
`default_nettype none

package drx_pkg;

    // frame limit and framing symbols
    localparam int unsigned MAX_FRAME = 300;
    localparam int unsigned BCNT_W    = 9;
    localparam logic [7:0] SYM_DLE    = 8'h10;
    localparam logic [7:0] SYM_ACK    = 8'h16;
    localparam logic [7:0] SYM_NAK    = 8'h19;
    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [15:0] CRC_TOP   = 16'h8000;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE      = 1'd1;

    // reset values of the configuration registers
    localparam logic       RST_CHECKSUM_MODE = 1'b1;
    localparam logic [7:0] RST_END_BYTE      = 8'h1f;

    // checksum mode codes
    localparam logic MODE_SUM = 1'b0;
    localparam logic MODE_CRC = 1'b1;

    typedef enum logic [2:0] {
        OUT_NONE     = 3'd0,
        OUT_ACK      = 3'd1,
        OUT_NAK      = 3'd2,
        OUT_CHK_ERR  = 3'd3,
        OUT_DATA_OK  = 3'd4,
        OUT_TIMEOUT  = 3'd5
    } t_outcome;

    // command codes of an input item
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic              byte_stored;
        logic [7:0]        stored_byte;
        logic [BCNT_W-1:0] byte_index;
        t_outcome          outcome;
        logic [7:0]        frame_command;
        logic [7:0]        error_code;
        logic [15:0]       received_checksum;
        logic [15:0]       computed_checksum;
    } t_out_item;

    // classified item passed from the front to the engine
    typedef struct packed {
        logic       timeout;
        logic       is_dle;
        logic       is_end;
        logic       is_ack;
        logic       is_nak;
        logic [7:0] data;
    } t_cls_item;

    // crc-16 (poly 0x8005, msb first) update by one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] e;
        logic [15:0] t;
        e = 16'h0000;
        t = {c[15:8] ^ b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (((e ^ t) & CRC_TOP) != 16'h0000) begin
                e = (e << 1) ^ CRC_POLY;
            end else begin
                e = e << 1;
            end
            t = t << 1;
        end
        return (c << 8) ^ e;
    endfunction

endpackage

`default_nettype wire

// File: design/dle_frame_receiver_crc16_core.sv
// top level of the dle frame receiver with crc-16 or sum checking
//
//   channel   handshake        payload
//   input     push / full      i_in_item  (command, data_byte)
//   result    empty / pop      o_out_item (one result per input item)
//   config    i_cfg_we         i_cfg_idx, i_cfg_data
//
// one item per clock while the result queue has room; the engine works on the head
// of the registered input queue and writes its result into the result queue, from
// which the result can then transfer.
// the engine does the byte-wide crc update of each item combinationally.
// reset (synchronous, active low) clears frame state and both queues and loads
// checksum_mode = crc and end_byte = 0x1f.
// a full result queue stalls the engine; the input queue then fills and raises full.
`default_nettype none

module dle_frame_receiver_crc16_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire drx_pkg::t_in_item               i_in_item,
    output logic                                 empty,
    input  wire logic                            pop,
    output drx_pkg::t_out_item                   o_out_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [drx_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [7:0]                      i_cfg_data
);
    import drx_pkg::*;

    logic      r_checksum_mode;
    logic [7:0] r_end_byte;
    logic      front_valid;
    t_cls_item front_item;
    logic      eng_take;
    logic      eng_push;
    t_out_item eng_result;
    logic      out_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checksum_mode <= RST_CHECKSUM_MODE;
            r_end_byte      <= RST_END_BYTE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHECKSUM_MODE: r_checksum_mode <= i_cfg_data[0];
                CFG_END_BYTE:      r_end_byte      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify
    drx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .i_end_byte (r_end_byte),
        .o_valid    (front_valid),
        .o_item     (front_item),
        .i_take     (eng_take)
    );

    // back: frame engine
    drx_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_checksum_mode (r_checksum_mode),
        .i_valid         (front_valid),
        .i_item          (front_item),
        .o_take          (eng_take),
        .i_out_full      (out_full),
        .o_push          (eng_push),
        .o_result        (eng_result)
    );

    // result queue
    drx_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (eng_push),
        .i_result   (eng_result),
        .o_full     (out_full),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

// File: design/drx_front.sv
// front part: accepts input items, classifies them and queues them for the engine
`default_nettype none

module drx_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire drx_pkg::t_in_item i_in_item,
    input  wire logic [7:0]        i_end_byte,
    output logic                   o_valid,
    output drx_pkg::t_cls_item     o_item,
    input  wire logic              i_take
);
    import drx_pkg::*;

    t_cls_item  r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_cls_item  cls;
    logic       do_push;
    logic       do_pop;

    // classify the incoming item
    always_comb begin
        cls.timeout = (i_in_item.command == CMD_TIMEOUT);
        cls.is_dle  = (i_in_item.data_byte == SYM_DLE);
        cls.is_end  = (i_in_item.data_byte == i_end_byte);
        cls.is_ack  = (i_in_item.data_byte == SYM_ACK);
        cls.is_nak  = (i_in_item.data_byte == SYM_NAK);
        cls.data    = i_in_item.data_byte;
    end

    assign full    = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rd_ptr];
    assign do_push = push && !full;
    assign do_pop  = i_take && o_valid;

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

`default_nettype wire

// File: design/drx_engine.sv
// back part: frame state machine, running checksum and result generation
`default_nettype none

module drx_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_checksum_mode,
    input  wire logic               i_valid,
    input  wire drx_pkg::t_cls_item i_item,
    output logic                    o_take,
    input  wire logic               i_out_full,
    output logic                    o_push,
    output drx_pkg::t_out_item      o_result
);
    import drx_pkg::*;

    logic              r_in_frame, n_in_frame;
    logic              r_last_dle, n_last_dle;
    logic              r_end_seen, n_end_seen;
    logic              r_nak_seen, n_nak_seen;
    logic [BCNT_W-1:0] r_byte_count, n_byte_count;
    logic [1:0]        r_trailer_count, n_trailer_count;
    logic [7:0]        r_trailer_high, n_trailer_high;
    logic [15:0]       r_chk, n_chk;
    logic [7:0]        r_frame_cmd, n_frame_cmd;

    logic              fire;
    logic              overflow;
    logic              s_in_frame, s_last_dle, s_end_seen, s_nak_seen;
    logic [BCNT_W-1:0] s_byte_count;
    logic [1:0]        s_trailer_count;
    logic [7:0]        s_trailer_high;
    logic [15:0]       s_chk;
    logic [7:0]        s_frame_cmd;
    logic [15:0]       chk_add;
    logic              stored, add, complete, acked, err_byte, start;
    logic [15:0]       rcv;
    logic [BCNT_W-1:0] base_count;

    assign fire   = i_valid && !i_out_full;
    assign o_take = fire;
    assign o_push = fire;

    // effective state after the silent frame-full clear
    always_comb begin
        overflow        = (r_byte_count >= BCNT_W'(MAX_FRAME));
        s_in_frame      = overflow ? 1'b0 : r_in_frame;
        s_last_dle      = overflow ? 1'b0 : r_last_dle;
        s_end_seen      = overflow ? 1'b0 : r_end_seen;
        s_nak_seen      = overflow ? 1'b0 : r_nak_seen;
        s_byte_count    = overflow ? '0 : r_byte_count;
        s_trailer_count = overflow ? 2'd0 : r_trailer_count;
        s_trailer_high  = overflow ? 8'h00 : r_trailer_high;
        s_chk           = overflow ? 16'h0000 : r_chk;
        s_frame_cmd     = overflow ? 8'h00 : r_frame_cmd;
        chk_add = (i_checksum_mode == MODE_CRC) ? crc16_byte(s_chk, i_item.data)
                                                : s_chk + {8'h00, i_item.data};
    end

    // framing decisions and result
    always_comb begin
        n_in_frame      = s_in_frame;
        n_last_dle      = s_last_dle;
        n_end_seen      = s_end_seen;
        n_nak_seen      = s_nak_seen;
        n_byte_count    = s_byte_count;
        n_trailer_count = s_trailer_count;
        n_trailer_high  = s_trailer_high;
        n_chk           = s_chk;
        n_frame_cmd     = s_frame_cmd;
        stored          = 1'b0;
        add             = 1'b0;
        complete        = 1'b0;
        acked           = 1'b0;
        err_byte        = 1'b0;
        start           = 1'b0;
        rcv             = 16'h0000;
        base_count      = s_byte_count;
        o_result        = '0;
        o_result.outcome = OUT_NONE;

        if (i_item.timeout) begin
            n_in_frame      = 1'b0;
            n_last_dle      = 1'b0;
            n_end_seen      = 1'b0;
            n_nak_seen      = 1'b0;
            n_byte_count    = '0;
            n_trailer_count = 2'd0;
            n_trailer_high  = 8'h00;
            n_chk           = 16'h0000;
            n_frame_cmd     = 8'h00;
            o_result.outcome = OUT_TIMEOUT;
        end else begin
            if (i_item.is_dle && !s_end_seen) begin
                if (!s_in_frame) begin
                    n_in_frame = 1'b1;
                    start      = 1'b1;
                    stored     = 1'b1;
                    add        = 1'b1;
                    n_last_dle = 1'b1;
                end else if (s_last_dle) begin
                    // stuffed copy: checksummed but not stored
                    add = 1'b1;
                end else begin
                    n_last_dle = 1'b1;
                    stored     = 1'b1;
                    add        = 1'b1;
                end
            end else if (i_item.is_end && s_last_dle && !s_end_seen) begin
                stored          = 1'b1;
                add             = 1'b1;
                n_end_seen      = 1'b1;
                n_trailer_count = 2'd0;
            end else if (s_end_seen) begin
                stored          = 1'b1;
                n_trailer_count = s_trailer_count + 2'd1;
                if (n_trailer_count >= 2'd2) begin
                    rcv      = {s_trailer_high, i_item.data};
                    complete = 1'b1;
                end else begin
                    n_trailer_high = i_item.data;
                end
            end else if (s_nak_seen) begin
                err_byte = 1'b1;
                complete = 1'b1;
                stored   = 1'b1;
            end else if (s_in_frame) begin
                // command byte right after the leading dle
                if (s_last_dle && s_byte_count == BCNT_W'(1)) begin
                    n_frame_cmd = i_item.data;
                    if (i_item.is_nak) begin
                        n_nak_seen = 1'b1;
                    end
                    if (i_item.is_ack) begin
                        acked    = 1'b1;
                        complete = 1'b1;
                    end
                end
                stored = 1'b1;
                add    = 1'b1;
            end

            if (add) begin
                n_chk = chk_add;
            end

            base_count = start ? '0 : s_byte_count;
            if (stored) begin
                n_byte_count         = base_count + BCNT_W'(1);
                o_result.byte_stored = 1'b1;
                o_result.stored_byte = i_item.data;
                o_result.byte_index  = base_count;
            end

            if (!i_item.is_dle) begin
                n_last_dle = 1'b0;
            end

            if (complete) begin
                if (acked) begin
                    o_result.outcome = OUT_ACK;
                end else if (n_nak_seen) begin
                    o_result.outcome = OUT_NAK;
                end else if (rcv != n_chk) begin
                    o_result.outcome = OUT_CHK_ERR;
                end else begin
                    o_result.outcome = OUT_DATA_OK;
                end
                o_result.frame_command     = n_frame_cmd;
                o_result.error_code        = err_byte ? i_item.data : 8'h00;
                o_result.received_checksum = rcv;
                o_result.computed_checksum = n_chk;
                n_in_frame      = 1'b0;
                n_last_dle      = 1'b0;
                n_end_seen      = 1'b0;
                n_nak_seen      = 1'b0;
                n_byte_count    = '0;
                n_trailer_count = 2'd0;
                n_trailer_high  = 8'h00;
                n_chk           = 16'h0000;
                n_frame_cmd     = 8'h00;
            end
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame      <= 1'b0;
            r_last_dle      <= 1'b0;
            r_end_seen      <= 1'b0;
            r_nak_seen      <= 1'b0;
            r_byte_count    <= '0;
            r_trailer_count <= 2'd0;
            r_trailer_high  <= 8'h00;
            r_chk           <= 16'h0000;
            r_frame_cmd     <= 8'h00;
        end else if (fire) begin
            r_in_frame      <= n_in_frame;
            r_last_dle      <= n_last_dle;
            r_end_seen      <= n_end_seen;
            r_nak_seen      <= n_nak_seen;
            r_byte_count    <= n_byte_count;
            r_trailer_count <= n_trailer_count;
            r_trailer_high  <= n_trailer_high;
            r_chk           <= n_chk;
            r_frame_cmd     <= n_frame_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/drx_out_queue.sv
// two-entry result queue in front of the output port
`default_nettype none

module drx_out_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire drx_pkg::t_out_item i_result,
    output logic                    o_full,
    output logic                    empty,
    input  wire logic               pop,
    output drx_pkg::t_out_item      o_out_item
);
    import drx_pkg::*;

    t_out_item  r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full     = (r_count == 2'd2);
    assign empty      = (r_count == 2'd0);
    assign o_out_item = r_q[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = pop && !empty;

    // pointers and fill count
    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/dle_frame_receiver_crc16_core_tb.sv
// self-checking testbench for the dle frame receiver core with crc-16 or sum checking
module dle_frame_receiver_crc16_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drx_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_GAP      = 19;
    localparam int HOLD_CYCLES  = 300;

    // block ports
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 push       = 1'b0;
    logic                 full;
    t_in_item             i_in_item  = '0;
    logic                 empty;
    logic                 pop        = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [7:0]           i_cfg_data = '0;

    // mirrored registers and frame state of the receiver
    logic       cfg_mode;
    logic [7:0] cfg_end;
    logic       fr_active;
    logic       fr_after_dle;
    logic       fr_end_seen;
    logic       fr_nak_seen;
    logic [8:0] fr_count;
    logic [1:0] fr_trail_cnt;
    logic [7:0] fr_trail_hi;
    logic [15:0] fr_chk;
    logic [7:0] fr_cmd;

    // bookkeeping shared by sender and checker
    t_out_item  expected_results[$];
    logic [7:0] payload_bytes[$];
    bit         reset_done      = 0;
    bit         tx_idle         = 1;
    bit         rx_idle         = 1;
    bit         full_seen       = 0;
    int         rx_hold_cycles  = 0;
    int         items_sent      = 0;
    int         ignored_items   = 0;
    int         results_checked = 0;
    int         error_count     = 0;
    int         config_phases   = 0;
    int         outcome_tally[8];

    dle_frame_receiver_crc16_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial forever #4 i_clk = ~i_clk;

    // running checksum update by one byte, crc is msb first with init 0
    function automatic logic [15:0] chk_add(input logic mode, input logic [15:0] c,
                                            input logic [7:0] b);
        logic [15:0] x;
        if (mode == MODE_SUM) begin
            return c + {8'h00, b};
        end
        x = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

    function automatic void clear_frame_state();
        fr_active    = 1'b0;
        fr_after_dle = 1'b0;
        fr_end_seen  = 1'b0;
        fr_nak_seen  = 1'b0;
        fr_count     = '0;
        fr_trail_cnt = '0;
        fr_trail_hi  = '0;
        fr_chk       = '0;
        fr_cmd       = '0;
    endfunction

    // advance the frame state by one item and return the result it causes
    function automatic t_out_item frame_predict(input t_in_item it);
        t_out_item   r;
        logic [7:0]  b;
        logic        kept;
        logic        done;
        logic        acked;
        logic        err_byte;
        logic [8:0]  pos;
        logic [15:0] rcv;
        r        = '0;
        b        = it.data_byte;
        kept     = 1'b0;
        done     = 1'b0;
        acked    = 1'b0;
        err_byte = 1'b0;
        pos      = '0;
        rcv      = '0;
        if (it.command == CMD_TIMEOUT) begin
            clear_frame_state();
            r.outcome = OUT_TIMEOUT;
            return r;
        end
        // frame limit reached: drop the frame, treat the byte as idle traffic
        if (fr_count >= MAX_FRAME) begin
            clear_frame_state();
        end
        if (b == SYM_DLE && !fr_end_seen) begin
            if (!fr_active) begin
                fr_active    = 1'b1;
                fr_count     = '0;
                kept         = 1'b1;
                fr_chk       = chk_add(cfg_mode, fr_chk, b);
                fr_after_dle = 1'b1;
            end else if (fr_after_dle) begin
                // stuffed copy: checksummed, not stored
                fr_chk = chk_add(cfg_mode, fr_chk, b);
            end else begin
                fr_after_dle = 1'b1;
                kept         = 1'b1;
                fr_chk       = chk_add(cfg_mode, fr_chk, b);
            end
        end else if (b == cfg_end && fr_after_dle && !fr_end_seen) begin
            kept         = 1'b1;
            fr_chk       = chk_add(cfg_mode, fr_chk, b);
            fr_end_seen  = 1'b1;
            fr_trail_cnt = '0;
        end else if (fr_end_seen) begin
            kept         = 1'b1;
            fr_trail_cnt = fr_trail_cnt + 2'd1;
            if (fr_trail_cnt >= 2'd2) begin
                rcv  = {fr_trail_hi, b};
                done = 1'b1;
            end else begin
                fr_trail_hi = b;
            end
        end else if (fr_nak_seen) begin
            err_byte = 1'b1;
            done     = 1'b1;
            kept     = 1'b1;
        end else if (fr_active) begin
            if (fr_after_dle && fr_count == 9'd1) begin
                fr_cmd = b;
                if (b == SYM_NAK) begin
                    fr_nak_seen = 1'b1;
                end
                if (b == SYM_ACK) begin
                    acked = 1'b1;
                    done  = 1'b1;
                end
            end
            kept   = 1'b1;
            fr_chk = chk_add(cfg_mode, fr_chk, b);
        end
        if (kept) begin
            pos      = fr_count;
            fr_count = fr_count + 9'd1;
        end
        if (b != SYM_DLE) begin
            fr_after_dle = 1'b0;
        end
        r.byte_stored = kept;
        r.stored_byte = kept ? b : 8'h00;
        r.byte_index  = pos;
        if (done) begin
            if (acked) begin
                r.outcome = OUT_ACK;
            end else if (fr_nak_seen) begin
                r.outcome = OUT_NAK;
            end else if (rcv != fr_chk) begin
                r.outcome = OUT_CHK_ERR;
            end else begin
                r.outcome = OUT_DATA_OK;
            end
            r.frame_command     = fr_cmd;
            r.error_code        = err_byte ? b : 8'h00;
            r.received_checksum = rcv;
            r.computed_checksum = fr_chk;
            clear_frame_state();
        end
        return r;
    endfunction

    // random command byte that starts an ordinary data frame
    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == SYM_DLE || c == SYM_ACK || c == SYM_NAK || c == cfg_end);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at result %0d, %s: got %0h, expected %0h",
                 results_checked, what, got, want);
        error_count++;
    endtask

    // one input transfer, with a random lead-in gap while tx_idle is set
    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        do begin
            @(posedge i_clk);
            if (full) begin
                full_seen = 1;
            end
        end while (full);
        expected_results.push_back(frame_predict(it));
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it.command   = CMD_BYTE;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic send_timeout(input logic [7:0] b);
        t_in_item it;
        it.command   = CMD_TIMEOUT;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic fill_payload(input int len, input bit allow_dle);
        logic [7:0] b;
        payload_bytes.delete();
        repeat (len) begin
            b = (allow_dle && $urandom_range(0, 5) == 0) ? SYM_DLE : 8'($urandom_range(0, 255));
            if (!allow_dle && b == SYM_DLE) begin
                b = 8'h11;
            end
            payload_bytes.push_back(b);
        end
    endtask

    // full frame: dle, command, stuffed payload, dle end, checksum high then low
    task automatic send_data_frame(input logic [7:0] cmd, input bit corrupt);
        logic [7:0]  line_bytes[$];
        logic [15:0] chk;
        line_bytes.push_back(SYM_DLE);
        line_bytes.push_back(cmd);
        for (int k = 0; k < payload_bytes.size(); k++) begin
            line_bytes.push_back(payload_bytes[k]);
            if (payload_bytes[k] == SYM_DLE) begin
                line_bytes.push_back(SYM_DLE);
            end
        end
        line_bytes.push_back(SYM_DLE);
        line_bytes.push_back(cfg_end);
        chk = '0;
        for (int k = 0; k < line_bytes.size(); k++) begin
            chk = chk_add(cfg_mode, chk, line_bytes[k]);
        end
        if (corrupt) begin
            chk = chk ^ 16'($urandom_range(1, 65535));
        end
        line_bytes.push_back(chk[15:8]);
        line_bytes.push_back(chk[7:0]);
        for (int k = 0; k < line_bytes.size(); k++) begin
            send_byte(line_bytes[k]);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_for_drain();
        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write both registers back to back, only while the block is idle
    task automatic configure(input logic mode, input logic [7:0] endb);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CHECKSUM_MODE;
        i_cfg_data <= {7'($urandom_range(0, 127)), mode};
        @(posedge i_clk);
        cfg_mode    = mode;
        i_cfg_idx  <= CFG_END_BYTE;
        i_cfg_data <= endb;
        @(posedge i_clk);
        cfg_end     = endb;
        i_cfg_we   <= 1'b0;
        config_phases++;
    endtask

    // ack, nak, good and bad data frames under reset settings
    task automatic test_basic_frames();
        send_byte(SYM_DLE);
        send_byte(SYM_ACK);
        send_byte(SYM_DLE);
        send_byte(SYM_NAK);
        send_byte(8'hff);
        payload_bytes.delete();
        payload_bytes.push_back(SYM_DLE);
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'hff);
        send_data_frame(8'h41, 0);
        payload_bytes.delete();
        send_data_frame(8'hfe, 1);
    endtask

    // nak frame ended by its trailer, and a nak with a zero error code
    task automatic test_nak_with_trailer();
        payload_bytes.delete();
        send_data_frame(SYM_NAK, 0);
        send_byte(SYM_DLE);
        send_byte(SYM_NAK);
        send_byte(8'h00);
    endtask

    // bytes outside a frame are dropped; timeout aborts a frame
    task automatic test_noise_and_timeout();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(SYM_DLE);
        send_byte(8'h20);
        send_timeout(8'hff);
        send_timeout(8'h00);
    endtask

    // byte sum checking and end byte extremes
    task automatic test_sum_mode();
        wait_for_drain();
        configure(MODE_SUM, 8'hff);
        payload_bytes.delete();
        repeat (3) payload_bytes.push_back(8'hff);
        send_data_frame(8'h01, 0);
        send_data_frame(8'h01, 1);
        wait_for_drain();
        configure(MODE_CRC, 8'h00);
        payload_bytes.delete();
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'h01);
        send_data_frame(8'h7f, 0);
        wait_for_drain();
        configure(MODE_CRC, RST_END_BYTE);
    endtask

    // end byte equal to dle: the frame can never close through its end marker
    task automatic test_end_byte_is_dle();
        wait_for_drain();
        configure(MODE_CRC, SYM_DLE);
        fill_payload(4, 0);
        send_data_frame(pick_command(), 0);
        send_timeout(8'($urandom_range(0, 255)));
        wait_for_drain();
        configure(MODE_SUM, RST_END_BYTE);
    endtask

    // frames at and beyond the frame limit, each followed by a short ack frame
    task automatic test_frame_full();
        int lens[4];
        lens = '{295, 296, 297, 300};
        for (int k = 0; k < 4; k++) begin
            fill_payload(lens[k], 0);
            send_data_frame(pick_command(), 0);
            send_byte(SYM_DLE);
            send_byte(SYM_ACK);
        end
    endtask

    // receiver holds off while the sender keeps offering until full shows
    task automatic test_backpressure();
        int guard;
        wait_for_drain();
        tx_idle        = 0;
        rx_idle        = 0;
        full_seen      = 0;
        rx_hold_cycles = HOLD_CYCLES;
        guard          = 0;
        while (!full_seen && guard < 40) begin
            fill_payload(8, 1);
            send_data_frame(pick_command(), 0);
            guard++;
        end
        // sender pauses until every result is back
        wait_for_drain();
        tx_idle = 1;
        rx_idle = 1;
    endtask

    // mostly well-formed frames with random content, plus noise and broken frames
    task automatic test_random_traffic();
        int         action;
        int         goal;
        int         len;
        logic       mode;
        logic [7:0] endb;
        goal = items_sent - ignored_items + RANDOM_ITEMS;
        while (items_sent - ignored_items < goal) begin
            wait_for_drain();
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0: endb = 8'h00;
                1: endb = 8'hff;
                2: endb = RST_END_BYTE;
                3: endb = SYM_DLE;
                default: endb = 8'($urandom_range(0, 255));
            endcase
            configure(mode, endb);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat (30) begin
                action = $urandom_range(0, 99);
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                if (action < 55) begin
                    fill_payload(len, 1);
                    send_data_frame(pick_command(), 0);
                end else if (action < 63) begin
                    send_byte(SYM_DLE);
                    send_byte(SYM_ACK);
                end else if (action < 71) begin
                    send_byte(SYM_DLE);
                    send_byte(SYM_NAK);
                    send_byte(8'($urandom_range(0, 255)));
                end else if (action < 75) begin
                    payload_bytes.delete();
                    send_data_frame(SYM_NAK, 0);
                end else if (action < 83) begin
                    fill_payload(len, 1);
                    send_data_frame(pick_command(), 1);
                end else if (action < 89) begin
                    // frame cut short, the next one runs into it
                    send_byte(SYM_DLE);
                    send_byte(pick_command());
                    repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
                end else if (action < 95) begin
                    send_byte(8'($urandom_range(0, 255)));
                    ignored_items++;
                end else begin
                    send_timeout(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // result side: random stalls, long hold-off on request, field checks
    initial begin : result_checker
        int        stall;
        t_out_item got;
        t_out_item want;
        wait (reset_done);
        forever begin
            if (rx_hold_cycles > 0) begin
                pop <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = o_out_item;
            results_checked++;
            outcome_tally[int'(got.outcome)]++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", int'(got.outcome), 0);
            end else begin
                want = expected_results.pop_front();
                if (got.byte_stored != want.byte_stored)
                    report_mismatch("byte_stored", got.byte_stored, want.byte_stored);
                if (got.stored_byte != want.stored_byte)
                    report_mismatch("stored_byte", got.stored_byte, want.stored_byte);
                if (got.byte_index != want.byte_index)
                    report_mismatch("byte_index", got.byte_index, want.byte_index);
                if (got.outcome != want.outcome)
                    report_mismatch("outcome", int'(got.outcome), int'(want.outcome));
                if (got.frame_command != want.frame_command)
                    report_mismatch("frame_command", got.frame_command, want.frame_command);
                if (got.error_code != want.error_code)
                    report_mismatch("error_code", got.error_code, want.error_code);
                if (got.received_checksum != want.received_checksum)
                    report_mismatch("received_checksum", got.received_checksum,
                                    want.received_checksum);
                if (got.computed_checksum != want.computed_checksum)
                    report_mismatch("computed_checksum", got.computed_checksum,
                                    want.computed_checksum);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : stall_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("dle_frame_receiver_crc16_core_tb: errors");
        $finish;
    end

    // reset, test sequence, summary
    initial begin : test_sequence
        cfg_mode = RST_CHECKSUM_MODE;
        cfg_end  = RST_END_BYTE;
        clear_frame_state();
        for (int k = 0; k < 8; k++) begin
            outcome_tally[k] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_done = 1;

        test_basic_frames();
        test_nak_with_trailer();
        test_noise_and_timeout();
        test_sum_mode();
        test_end_byte_is_dle();
        test_frame_full();
        test_backpressure();
        test_random_traffic();

        wait_for_drain();
        repeat (8) @(posedge i_clk);
        $display("%0d items sent, %0d results checked over %0d register settings",
                 items_sent, results_checked, config_phases);
        $display("outcomes: ack %0d, nak %0d, bad checksum %0d, good %0d, timeout %0d",
                 outcome_tally[OUT_ACK], outcome_tally[OUT_NAK], outcome_tally[OUT_CHK_ERR],
                 outcome_tally[OUT_DATA_OK], outcome_tally[OUT_TIMEOUT]);
        if (error_count == 0) begin
            $display("dle_frame_receiver_crc16_core_tb: clean");
        end else begin
            $display("dle_frame_receiver_crc16_core_tb: errors");
        end
        $finish;
    end

endmodule

// File: dle_frame_receiver_crc16_core.f
design/drx_pkg.sv
design/drx_front.sv
design/drx_engine.sv
design/drx_out_queue.sv
design/dle_frame_receiver_crc16_core.sv
tb/sv/dle_frame_receiver_crc16_core_tb.sv
